// File: rtl/mtp_pkg.sv
`timescale 1ns / 1ps

package mtp_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int AW           = $clog2(STATE_WORDS + 2);

    localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] MT_SEED_MULT    = 32'd69069;
    localparam logic [31:0] MT_DEFAULT_SEED = 32'd4357;

    localparam logic [AW-1:0] POS_EMPTY    = AW'(STATE_WORDS);
    localparam logic [AW-1:0] POS_UNSEEDED = AW'(STATE_WORDS + 1);
    localparam logic [AW-1:0] IDX_LAST     = AW'(STATE_WORDS - 1);

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRE,
        ST_TW_RD,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_LD
    } t_state;

    typedef struct packed {
        logic seed_load;     // load seed register, restart index, mark table used up
        logic seed_default;  // pick the default seed on seed_load
        logic seed_step;     // write one seed word, advance the multiply chain
        logic tw_start;      // index to 0, fetch word 0
        logic tw_read;       // fetch far and next words for the current index
        logic tw_write;      // write the twisted word, advance index
        logic draw_read;     // fetch word at read position, advance position
        logic out_load;      // temper fetched word into the output register
    } t_cmd;

    typedef struct packed {
        logic unseeded;
        logic empty;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/mtp_ctrl.sv
`timescale 1ns / 1ps

module mtp_ctrl
    import mtp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_draw_pend, n_draw_pend;
    logic   accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_draw_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_draw_pend <= n_draw_pend;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_draw_pend = r_draw_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_SEED) begin
                        n_state     = ST_SEED;
                        n_draw_pend = 1'b0;
                    end else if (i_status.unseeded) begin
                        n_state     = ST_SEED;
                        n_draw_pend = 1'b1;
                    end else if (i_status.empty) begin
                        n_state = ST_TW_PRE;
                    end else begin
                        n_state = ST_DRAW_LD;
                    end
                end
            end
            ST_SEED: begin
                if (i_status.idx_last) begin
                    n_state     = r_draw_pend ? ST_TW_PRE : ST_IDLE;
                    n_draw_pend = 1'b0;
                end
            end
            ST_TW_PRE:  n_state = ST_TW_RD;
            ST_TW_RD:   n_state = ST_TW_WR;
            ST_TW_WR:   n_state = i_status.idx_last ? ST_DRAW_RD : ST_TW_RD;
            ST_DRAW_RD: n_state = ST_DRAW_LD;
            ST_DRAW_LD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_SEED) begin
                        o_cmd.seed_load = 1'b1;
                    end else if (i_status.unseeded) begin
                        o_cmd.seed_load    = 1'b1;
                        o_cmd.seed_default = 1'b1;
                    end else if (!i_status.empty) begin
                        o_cmd.draw_read = 1'b1;
                    end
                end
            end
            ST_SEED:    o_cmd.seed_step = 1'b1;
            ST_TW_PRE:  o_cmd.tw_start  = 1'b1;
            ST_TW_RD:   o_cmd.tw_read   = 1'b1;
            ST_TW_WR:   o_cmd.tw_write  = 1'b1;
            ST_DRAW_RD: o_cmd.draw_read = 1'b1;
            ST_DRAW_LD: o_cmd.out_load  = i_status.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/mtp_datapath.sv
`timescale 1ns / 1ps

module mtp_datapath
    import mtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed_value,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word
);

    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] y;
        y = v ^ (v >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [31:0] mem [STATE_WORDS];

    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0]   r_seed, n_seed;
    logic [31:0]   r_cur;
    logic [31:0]   r_rd_a, r_rd_b;
    logic [31:0]   r_out;
    logic          r_valid;

    logic [AW-1:0] idx_next, idx_far, addr_a, addr_b;
    logic          rd_a_en, rd_b_en;
    logic          wr_en;
    logic [31:0]   wr_data;
    logic [31:0]   y_mix;
    logic [31:0]   tw_word;

    assign idx_next = (r_idx == IDX_LAST) ? '0 : r_idx + AW'(1);
    assign idx_far  = (r_idx < AW'(STATE_WORDS - TWIST_OFFSET))
                    ? r_idx + AW'(TWIST_OFFSET)
                    : r_idx - AW'(STATE_WORDS - TWIST_OFFSET);

    assign y_mix   = {r_cur[31], r_rd_b[30:0]};
    assign tw_word = r_rd_a ^ (y_mix >> 1) ^ (y_mix[0] ? MT_MATRIX : 32'd0);

    always_comb begin
        rd_a_en = i_cmd.tw_read || i_cmd.draw_read;
        addr_a  = i_cmd.tw_read ? idx_far : r_pos;
        rd_b_en = i_cmd.tw_read || i_cmd.tw_start;
        addr_b  = i_cmd.tw_read ? idx_next : '0;
        wr_en   = i_cmd.seed_step || i_cmd.tw_write;
        wr_data = i_cmd.tw_write ? tw_word : r_seed;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx] <= wr_data;
        end
        if (rd_a_en) begin
            r_rd_a <= mem[addr_a];
        end
        if (rd_b_en) begin
            r_rd_b <= mem[addr_b];
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_idx  = r_idx;
        n_seed = r_seed;
        if (i_cmd.seed_load) begin
            n_seed = i_cmd.seed_default ? MT_DEFAULT_SEED : i_seed_value;
            n_idx  = '0;
            n_pos  = POS_EMPTY;
        end
        if (i_cmd.seed_step) begin
            n_seed = r_seed * MT_SEED_MULT;
            n_idx  = r_idx + AW'(1);
        end
        if (i_cmd.tw_start) begin
            n_idx = '0;
        end
        if (i_cmd.tw_write) begin
            n_idx = r_idx + AW'(1);
            if (r_idx == IDX_LAST) begin
                n_pos = '0;
            end
        end
        if (i_cmd.draw_read) begin
            n_pos = r_pos + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_UNSEEDED;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_idx <= n_idx;
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
        // word k still holds its fetched value: only k-1 was written since
        if (i_cmd.tw_read) begin
            r_cur <= r_rd_b;
        end
        if (i_cmd.out_load) begin
            r_out <= temper(r_rd_a);
        end
    end

    assign o_status.unseeded = (r_pos == POS_UNSEEDED);
    assign o_status.empty    = (r_pos == POS_EMPTY);
    assign o_status.idx_last = (r_idx == IDX_LAST);
    assign o_status.out_free = !r_valid || !i_stall;

    assign o_valid       = r_valid;
    assign o_random_word = r_out;

endmodule

// File: rtl/mersenne_twister_prng.sv
`timescale 1ns / 1ps
// MT19937 generator, one item at a time.
// Draw from a live table: table read, then temper into the output register; the next
// item is taken once the result is loaded, and a stalled output holds that load off.
// Reseed: one seed word per cycle through the 69069 multiply chain.
// Draw after the table is used up first regenerates it (twist start, a read and a write per word, reread).
// Synchronous active-low reset clears control; the table stays undefined, unseeded.

module mersenne_twister_prng
    import mtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word
);

    t_cmd    cmd;
    t_status status;

    mtp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mtp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_value  (i_seed_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

endmodule

// File: tb/tb_mersenne_twister_prng.sv
`timescale 1ns / 1ps

module tb_mersenne_twister_prng;
    import mtp_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          N_ITEMS        = 1400;
    localparam int          N_CALM         = 150;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          N_DIR          = 20;
    localparam logic [31:0] WORD_UPPER     = 32'h8000_0000;
    localparam logic [31:0] WORD_LOWER     = 32'h7fff_ffff;
    localparam logic        WORD_PRED      = 1'b0;
    localparam logic        WORD_KNOWN     = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] seed;
        logic        known;
        logic [31:0] word;
    } t_dir_row;

    // zero seed fills the table with zeros, so every draw after it is zero until the next reseed
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},  // draw before any seed
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_SEED, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h0000_0000, WORD_KNOWN, 32'h0},
        '{FUNC_DRAW, 32'hffff_ffff, WORD_KNOWN, 32'h0},  // seed field ignored on draw
        '{FUNC_SEED, 32'hffff_ffff, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h1234_5678, WORD_PRED,  32'h0},
        '{FUNC_SEED, 32'h0000_0001, WORD_PRED,  32'h0},
        '{FUNC_SEED, MT_DEFAULT_SEED, WORD_PRED, 32'h0}, // back-to-back reseed
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_SEED, 32'h8000_0000, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_SEED, 32'h7fff_ffff, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h0000_0000, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'hffff_ffff, WORD_PRED,  32'h0},
        '{FUNC_SEED, 32'h0000_0000, WORD_PRED,  32'h0},  // reseed mid-table
        '{FUNC_DRAW, 32'h0000_0000, WORD_KNOWN, 32'h0},
        '{FUNC_SEED, 32'ha5a5_a5a5, WORD_PRED,  32'h0},
        '{FUNC_DRAW, 32'h5a5a_5a5a, WORD_PRED,  32'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [31:0] i_seed_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_random_word;

    // known expectation travels with the item it belongs to
    logic        drv_known;
    logic [31:0] drv_word;

    logic [31:0] gen_words [STATE_WORDS];
    int          gen_pos;
    logic [31:0] words_due [$];

    int items_in;
    int items_sent;
    int draws_seen;
    int seeds_seen;
    int regens;
    int words_checked;
    int errors;
    int quiet_cycles;
    bit pace_on;

    mersenne_twister_prng i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_seed_value  (i_seed_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // generator model
    function automatic void gen_fill(input logic [31:0] seed);
        gen_words[0] = seed;
        for (int k = 1; k < STATE_WORDS; k++) begin
            gen_words[k] = gen_words[k - 1] * MT_SEED_MULT;
        end
        gen_pos = STATE_WORDS;
    endfunction

    function automatic void gen_regen();
        logic [31:0] y;
        for (int k = 0; k < STATE_WORDS; k++) begin
            y = (gen_words[k] & WORD_UPPER) | (gen_words[(k + 1) % STATE_WORDS] & WORD_LOWER);
            gen_words[k] = gen_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
                         ^ (y[0] ? MT_MATRIX : 32'h0);
        end
        regens++;
    endfunction

    function automatic logic [31:0] gen_next_word();
        logic [31:0] y;
        if (gen_pos >= STATE_WORDS) begin
            if (gen_pos != STATE_WORDS) begin
                gen_fill(MT_DEFAULT_SEED);
            end
            gen_regen();
            gen_pos = 0;
        end
        y = gen_words[gen_pos];
        gen_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & MT_TEMPER_B;
        y ^= (y << 15) & MT_TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    initial begin
        for (int k = 0; k < STATE_WORDS; k++) begin
            gen_words[k] = 32'h0;
        end
        gen_pos = STATE_WORDS + 1;
    end

    // accept, predict, check, watchdog
    always @(posedge i_clk) begin : monitor
        logic [31:0] want;
        logic [31:0] model_word;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            moved = 1'b1;
            items_in++;
            if (i_func == FUNC_SEED) begin
                seeds_seen++;
                gen_fill(i_seed_value);
            end else begin
                draws_seen++;
                model_word = gen_next_word();
                words_due.push_back(drv_known ? drv_word : model_word);
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (words_due.size() == 0) begin
                $display("%0t: random_word expected none, got %08h", $time, o_random_word);
                errors++;
            end else begin
                want = words_due.pop_front();
                words_checked++;
                if (o_random_word !== want) begin
                    $display("%0t: random_word expected %08h, got %08h",
                             $time, want, o_random_word);
                    errors++;
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results pending",
                     $time, quiet_cycles, words_due.size());
            $display("tb_mersenne_twister_prng: done, errors");
            $finish;
        end
    end

    // result-side backpressure
    initial begin : rx_pacing
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pace_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 14);
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input logic f, input logic [31:0] s,
                             input logic k, input logic [31:0] w);
        int gap;
        int seen;
        if (items_sent >= N_ITEMS - N_CALM) begin
            pace_on = 1'b0;
        end
        if (pace_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid      <= 1'b0;
            i_func       <= 1'($urandom_range(0, 1));
            i_seed_value <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        seen = items_in;
        i_valid      <= 1'b1;
        i_func       <= f;
        i_seed_value <= s;
        drv_known    <= k;
        drv_word     <= w;
        do @(negedge i_clk); while (items_in == seen);
        items_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          run;
        int          seg;
        logic [31:0] seed;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FUNC_DRAW;
        i_seed_value = 32'h0;
        drv_known    = WORD_PRED;
        drv_word     = 32'h0;
        pace_on      = 1'b0;
        items_in     = 0;
        items_sent   = 0;
        draws_seen   = 0;
        seeds_seen   = 0;
        regens       = 0;
        words_checked = 0;
        errors       = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            send_item(DIR_ROWS[r].func, DIR_ROWS[r].seed, DIR_ROWS[r].known, DIR_ROWS[r].word);
        end
        drain_results();

        // each segment: reseed, then a run of draws; long runs cross a table regeneration
        seg = 0;
        while (items_sent < N_ITEMS) begin
            pace_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       seed = 32'h0;
                1:       seed = 32'hffff_ffff;
                2:       seed = MT_DEFAULT_SEED;
                default: seed = $urandom;
            endcase
            send_item(FUNC_SEED, seed, WORD_PRED, 32'h0);
            if (seg == 0 || $urandom_range(0, 5) == 0) begin
                run = $urandom_range(600, 700);
            end else begin
                run = $urandom_range(0, 30);
            end
            for (int d = 0; d < run && items_sent < N_ITEMS; d++) begin
                send_item(FUNC_DRAW, $urandom, WORD_PRED, 32'h0);
            end
            if ($urandom_range(0, 4) == 0) begin
                drain_results();
            end
            seg++;
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        errors += words_due.size();
        $display("summary: %0d draws, %0d reseeds, %0d table regenerations, %0d words checked",
                 draws_seen, seeds_seen, regens, words_checked);
        if (errors == 0) begin
            $display("tb_mersenne_twister_prng: done, clean");
        end else begin
            $display("tb_mersenne_twister_prng: done, errors");
        end
        $finish;
    end

endmodule
